FILE: design/lnis_pkg.sv
`timescale 1ns / 1ps

package lnis_pkg;

  // Field widths fixed by the item formats.
  localparam int VAL_W = 32;
  localparam int POS_W = 7;

  // Default number of items a sequence may hold.
  localparam int MAX_ITEMS_DEF = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_PRED,
    S_BT0,
    S_BT1,
    S_WALK,
    S_EMIT,
    S_DRAIN
  } lnis_state_t;

endpackage

FILE: design/longest_nonincreasing_subsequence.sv
`timescale 1ns / 1ps

// Longest non-increasing subsequence finder.
//
// Input items arrive on in_value / in_is_last and are taken at a rising edge
// where start is high and busy is low. Each item is placed into a table of
// tail values by a binary search that reads one tail per clock cycle from the
// tail memory, with at most ceil(log2(L+1)) search probes for L tails in use.
// No new item is taken until this item's tail and its predecessor link are
// written. The tail memory's single read port allows one probe per cycle.
//
// An item with in_is_last set, or the item that fills the store to MAX_ITEMS,
// ends the sequence. The block then walks the predecessor chain, one memory
// read per element, and emits the chosen 1-based positions in increasing
// order on out_position, one per cycle, each marked by out_valid. Every result
// carries the length on out_length, and out_run_end flags the last one. The
// block returns to idle in the cycle after the last result is shown. Results
// cannot be held off: each is shown for exactly one cycle. Reset (rst_n low,
// synchronous, busy held high) empties the sequence, as does each emitted run.
module longest_nonincreasing_subsequence
  import lnis_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_is_last,
  output logic                    out_valid,
  output logic        [POS_W-1:0] out_position,
  output logic        [POS_W-1:0] out_length,
  output logic                    out_run_end
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int TW = VAL_W + AW;
  localparam int PW = AW + 1;
  localparam int LW = AW + 1;
  localparam int LD = 2 ** LW;

  lnis_state_t state_r, state_nxt;

  // Control and working registers.
  logic        [CW-1:0]    item_count_r, item_count_nxt;
  logic        [CW-1:0]    best_len_r, best_len_nxt;
  logic        [CW-1:0]    lo_r, lo_nxt;
  logic        [CW-1:0]    hi_r, hi_nxt;
  logic        [AW-1:0]    mid_r, mid_nxt;
  logic                    probe_r, probe_nxt;
  logic        [AW-1:0]    k_r, k_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    last_r, last_nxt;
  logic        [CW-1:0]    n_r, n_nxt;
  logic        [AW-1:0]    emit_idx_r, emit_idx_nxt;
  logic                    emit_vld_r, emit_vld_nxt;
  logic                    emit_last_r, emit_last_nxt;

  // Memory ports.
  logic                    tail_we;
  logic        [AW-1:0]    tail_waddr, tail_raddr;
  logic        [TW-1:0]    tail_wdata, tail_rdata;
  logic                    link_we;
  logic        [LW-1:0]    link_waddr, link_raddr;
  logic        [PW-1:0]    link_wdata, link_rdata;

  // Search step signals.
  logic signed [VAL_W-1:0] tail_val_rd;
  logic        [AW-1:0]    tail_pos_rd;
  logic        [CW-1:0]    lo_c, hi_c, lo_m1;
  logic        [CW:0]      mid_sum;
  logic                    search_more;
  logic        [AW-1:0]    item_idx;
  logic        [CW-1:0]    count_inc;
  logic        [CW-1:0]    k_inc;
  logic                    seq_end;
  logic                    pred_has;
  logic        [AW-1:0]    pred_idx;
  logic        [CW-1:0]    n_inc;

  assign tail_val_rd = tail_rdata[TW-1:AW];
  assign tail_pos_rd = tail_rdata[AW-1:0];
  assign pred_has    = link_rdata[PW-1];
  assign pred_idx    = link_rdata[AW-1:0];
  assign item_idx    = item_count_r[AW-1:0];
  assign count_inc   = item_count_r + CW'(1);
  assign k_inc       = CW'(k_r) + CW'(1);
  assign n_inc       = n_r + CW'(1);
  assign seq_end     = last_r || (count_inc >= CW'(MAX_ITEMS));

  // One binary-search step: fold in the tail read last cycle, then pick the next probe.
  always_comb begin
    lo_c = lo_r;
    hi_c = hi_r;
    if (probe_r) begin
      if (tail_val_rd >= val_r) begin
        lo_c = CW'(mid_r) + CW'(1);
      end else begin
        hi_c = CW'(mid_r);
      end
    end
    mid_sum     = {1'b0, lo_c} + {1'b0, hi_c};
    search_more = (lo_c < hi_c);
    lo_m1       = lo_c - CW'(1);
  end

  lnis_ram #(.DW(TW), .DEPTH(MAX_ITEMS)) u_tail_ram (
    .clk     (clk),
    .wr_en   (tail_we),
    .wr_addr (tail_waddr),
    .wr_data (tail_wdata),
    .rd_addr (tail_raddr),
    .rd_data (tail_rdata)
  );

  // The lower half holds each item's predecessor link, the upper half is the
  // reversal buffer filled during the backtrack. Links are only written while
  // items come in, and the buffer only while the chain is walked.
  lnis_ram #(.DW(PW), .DEPTH(LD)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_addr (link_raddr),
    .rd_data (link_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!search_more) begin
          state_nxt = S_PRED;
        end
      end
      S_PRED: begin
        state_nxt = seq_end ? S_BT0 : S_IDLE;
      end
      S_BT0: begin
        state_nxt = S_BT1;
      end
      S_BT1: begin
        state_nxt = (best_len_r <= CW'(1)) ? S_EMIT : S_WALK;
      end
      S_WALK: begin
        if (!pred_has || (n_inc >= best_len_r)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_idx_r == '0) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    item_count_nxt = item_count_r;
    best_len_nxt   = best_len_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    probe_nxt      = 1'b0;
    k_nxt          = k_r;
    val_nxt        = val_r;
    last_nxt       = last_r;
    n_nxt          = n_r;
    emit_idx_nxt   = emit_idx_r;
    emit_vld_nxt   = 1'b0;
    emit_last_nxt  = 1'b0;
    tail_we        = 1'b0;
    tail_waddr     = k_r;
    tail_wdata     = {val_r, item_idx};
    tail_raddr     = mid_r;
    link_we        = 1'b0;
    link_waddr     = {1'b0, item_idx};
    link_wdata     = '0;
    link_raddr     = {1'b1, emit_idx_r};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt  = in_value;
          last_nxt = in_is_last;
          lo_nxt   = '0;
          hi_nxt   = best_len_r;
        end
      end
      S_SEARCH: begin
        lo_nxt = lo_c;
        hi_nxt = hi_c;
        if (search_more) begin
          mid_nxt    = mid_sum[AW:1];
          tail_raddr = mid_sum[AW:1];
          probe_nxt  = 1'b1;
        end else begin
          // Fetch the tail one shorter to learn this item's predecessor.
          k_nxt      = lo_c[AW-1:0];
          tail_raddr = lo_m1[AW-1:0];
        end
      end
      S_PRED: begin
        tail_we        = 1'b1;
        link_we        = 1'b1;
        link_wdata     = (k_r != '0) ? {1'b1, tail_pos_rd} : '0;
        item_count_nxt = count_inc;
        if (k_inc > best_len_r) begin
          best_len_nxt = k_inc;
        end
      end
      S_BT0: begin
        tail_raddr = best_len_r[AW-1:0] - AW'(1);
      end
      S_BT1: begin
        link_we      = 1'b1;
        link_waddr   = {1'b1, AW'(0)};
        link_wdata   = {1'b0, tail_pos_rd};
        link_raddr   = {1'b0, tail_pos_rd};
        n_nxt        = CW'(1);
        emit_idx_nxt = '0;
      end
      S_WALK: begin
        link_raddr = {1'b0, pred_idx};
        if (!pred_has) begin
          emit_idx_nxt = n_r[AW-1:0] - AW'(1);
        end else begin
          link_we      = 1'b1;
          link_waddr   = {1'b1, n_r[AW-1:0]};
          link_wdata   = {1'b0, pred_idx};
          n_nxt        = n_inc;
          emit_idx_nxt = n_r[AW-1:0];
        end
      end
      S_EMIT: begin
        emit_vld_nxt  = 1'b1;
        emit_last_nxt = (emit_idx_r == '0);
        emit_idx_nxt  = emit_idx_r - AW'(1);
      end
      S_DRAIN: begin
        item_count_nxt = '0;
        best_len_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      item_count_r <= '0;
      best_len_r   <= '0;
      probe_r      <= 1'b0;
      emit_vld_r   <= 1'b0;
      emit_last_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      item_count_r <= item_count_nxt;
      best_len_r   <= best_len_nxt;
      probe_r      <= probe_nxt;
      emit_vld_r   <= emit_vld_nxt;
      emit_last_r  <= emit_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    k_r        <= k_nxt;
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    n_r        <= n_nxt;
    emit_idx_r <= emit_idx_nxt;
  end

  // The reversal buffer is read last entry first, so positions come out ascending.
  assign busy         = (state_r != S_IDLE) || !rst_n;
  assign out_valid    = emit_vld_r;
  assign out_run_end  = emit_last_r;
  assign out_position = POS_W'(link_rdata[AW-1:0]) + POS_W'(1);
  assign out_length   = POS_W'(n_r);

  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a run");

  a_run_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
    out_run_end |-> out_valid)
    else $error("run end without a result");

  a_tails_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    best_len_r <= item_count_r)
    else $error("more tails than items");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

endmodule

FILE: design/lnis_ram.sv
`timescale 1ns / 1ps

// Single-port-write, single-port-read synchronous memory with a registered read.
module lnis_ram
  import lnis_pkg::*;
#(
  parameter int DW    = VAL_W,
  parameter int DEPTH = MAX_ITEMS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: bench/longest_nonincreasing_subsequence_tb.sv
`timescale 1ns / 1ps

// Bench for the longest non-increasing subsequence finder.
//
// Items go in on the start/busy handshake. Each accepted item also goes into a
// shadow copy of the tail table held here. When an item closes its sequence,
// the shadow copy walks its own predecessor chain. The chosen positions are
// queued as the results the block must emit, oldest first. Results cannot be
// held off, so every cycle with out_valid high is checked against the head of
// that queue.
module longest_nonincreasing_subsequence_tb
  import lnis_pkg::*;
();

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 11;
  localparam int MAX_GAP       = 16;
  // The limit covers the wait from the last item to the start of a run of 64
  // results, and an item's wait of up to a MAX_GAP idle gap plus the busy time
  // of the item before. A longer quiet stretch therefore means the block has hung.
  localparam int STALL_LIMIT   = 2000;
  // Cycles to watch after the last expected result, so that stray results
  // are caught.
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS  = 20;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // Ways of drawing values for one random sequence.
  typedef enum int {
    VS_WIDE,
    VS_NARROW,
    VS_FALLING,
    VS_EXTREME
  } value_style_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] length;
    logic             run_end;
  } chosen_entry_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    start      = 1'b0;
  logic signed [VAL_W-1:0] in_value   = '0;
  logic                    in_is_last = 1'b0;
  wire                     busy;
  wire                     out_valid;
  wire         [POS_W-1:0] out_position;
  wire         [POS_W-1:0] out_length;
  wire                     out_run_end;

  longest_nonincreasing_subsequence u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_value    (in_value),
    .in_is_last  (in_is_last),
    .out_valid   (out_valid),
    .out_position(out_position),
    .out_length  (out_length),
    .out_run_end (out_run_end)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Shadow of the block's sequence state. Only entries written in the
  // current sequence are ever read, as in the block.
  logic signed [VAL_W-1:0] tail_val   [MAX_ITEMS_DEF];
  logic [5:0]              tail_item  [MAX_ITEMS_DEF];
  logic                    link_valid [MAX_ITEMS_DEF];
  logic [5:0]              link_item  [MAX_ITEMS_DEF];
  int unsigned             items_held   = 0;
  int unsigned             tails_in_use = 0;

  chosen_entry_t chosen_q[$];
  int            fail_count = 0;
  int            quiet_cycles = 0;

  // Gap before the next item. When it is zero, start stays high from one
  // acceptance straight into the next item.
  int            gap_before = 0;
  bit            quiet_stretch = 1'b0;

  // Places one value into the shadow tail table. When the item closes the
  // sequence, the chain is walked and the chosen positions are queued.
  function automatic void place_value(logic signed [VAL_W-1:0] v, logic last);
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   mid;
    int unsigned   slot;
    int unsigned   depth;
    int unsigned   cur;
    int unsigned   i;
    logic [5:0]    chain [MAX_ITEMS_DEF];
    chosen_entry_t entry;

    // Find the first tail strictly below v. Equal tails are passed over,
    // so that ties extend the chain.
    lo = 0;
    hi = tails_in_use;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (tail_val[mid] >= v) lo = mid + 1;
      else hi = mid;
    end
    slot = lo;

    tail_val[slot]        = v;
    tail_item[slot]       = items_held[5:0];
    link_valid[items_held] = (slot > 0);
    if (slot > 0) link_item[items_held] = tail_item[slot - 1];
    if (slot + 1 > tails_in_use) tails_in_use = slot + 1;
    items_held++;

    // A full store closes the sequence even without is_last.
    if (!last && items_held < MAX_ITEMS_DEF) return;

    depth = 0;
    cur   = tail_item[tails_in_use - 1];
    while (1) begin
      chain[depth] = cur[5:0];
      depth++;
      if (depth >= tails_in_use || !link_valid[cur]) break;
      cur = link_item[cur];
    end

    // The chain was walked from its end, so it is queued in reverse.
    for (i = 0; i < depth; i++) begin
      entry.position = chain[depth - 1 - i] + 7'd1;
      entry.length   = depth[POS_W-1:0];
      entry.run_end  = (i + 1 == depth);
      chosen_q.push_back(entry);
    end

    items_held   = 0;
    tails_in_use = 0;
  endfunction

  // Offers one item, waits until the block takes it, and then updates the
  // shadow state. The idle gap for the next item is drawn here. This way
  // start is lowered only when a gap really follows.
  task automatic send_item(input logic signed [VAL_W-1:0] v, input logic last);
    if (gap_before > 0) repeat (gap_before) @(posedge clk);
    start      <= 1'b1;
    in_value   <= v;
    in_is_last <= last;
    do @(posedge clk); while (busy);
    place_value(v, last);
    gap_before = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
    if (gap_before != 0) start <= 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] draw_value(value_style_t style,
                                                         logic signed [VAL_W-1:0] prev);
    logic signed [VAL_W-1:0] v;

    case (style)
      VS_NARROW: begin
        v = int'($urandom_range(0, 8)) - 4;
      end
      VS_FALLING: begin
        // Mostly small steps down with ties, and now and then a jump.
        if ($urandom_range(0, 7) == 0) v = $urandom;
        else v = prev - int'($urandom_range(0, 3));
      end
      VS_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = '0;
          3: v = -1;
          default: v = $urandom;
        endcase
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  // Single-item sequences at both ends of the value range.
  task automatic test_lone_extremes();
    send_item(VAL_MAX, 1'b1);
    send_item(VAL_MIN, 1'b1);
  endtask

  // Equal values chain, so the whole sequence is chosen.
  task automatic test_equal_values();
    send_item(32'sd7, 1'b0);
    send_item(32'sd7, 1'b0);
    send_item(32'sd7, 1'b0);
    send_item(32'sd7, 1'b1);
  endtask

  // A strictly rising sequence leaves a subsequence of length one.
  task automatic test_rising_run();
    send_item(-32'sd2, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sd2, 1'b1);
  endtask

  // Extremes mixed, so that the same tail gets replaced more than once.
  task automatic test_mixed_extremes();
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b1);
  endtask

  // A falling sequence with ties.
  task automatic test_falling_with_ties();
    send_item(32'sd9, 1'b0);
    send_item(32'sd4, 1'b0);
    send_item(32'sd4, 1'b0);
    send_item(32'sd1, 1'b1);
  endtask

  // The store fills without is_last, and the 64th item closes the sequence.
  // Mostly falling values make the emitted run long.
  task automatic test_full_store();
    logic signed [VAL_W-1:0] v;
    int                      i;

    v = $urandom;
    quiet_stretch = 1'b0;
    for (i = 0; i < MAX_ITEMS_DEF; i++) begin
      v = draw_value(VS_FALLING, v);
      send_item(v, 1'b0);
    end
  endtask

  // Short random sequences in varied value styles. Some run with no idle
  // gaps at all.
  task automatic test_random_sequences();
    logic signed [VAL_W-1:0] v;
    value_style_t            style;
    int                      seq_len;
    int                      sent;
    int                      i;

    sent = 0;
    v    = '0;
    while (sent < RANDOM_ITEMS) begin
      seq_len       = $urandom_range(1, 12);
      style         = value_style_t'($urandom_range(0, 3));
      quiet_stretch = ($urandom_range(0, 3) == 0);
      for (i = 0; i < seq_len; i++) begin
        v = draw_value(style, v);
        send_item(v, i == seq_len - 1);
      end
      sent += seq_len;
    end
    quiet_stretch = 1'b0;
  endtask

  // Checks every result in the cycle in which it is shown.
  always @(posedge clk) begin
    chosen_entry_t want;

    if (rst_n && out_valid) begin
      if (chosen_q.size() == 0) begin
        $error("out_position: no result expected, got %0d", out_position);
        fail_count++;
      end else begin
        want = chosen_q.pop_front();
        if (out_position !== want.position) begin
          $error("out_position: expected %0d, got %0d", want.position, out_position);
          fail_count++;
        end
        if (out_length !== want.length) begin
          $error("out_length: expected %0d, got %0d", want.length, out_length);
          fail_count++;
        end
        if (out_run_end !== want.run_end) begin
          $error("out_run_end: expected %0d, got %0d", want.run_end, out_run_end);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if neither an item nor a result moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_lone_extremes();
    test_equal_values();
    test_rising_run();
    test_mixed_extremes();
    test_falling_with_ties();
    test_full_store();
    test_random_sequences();

    // When no gap was drawn, start is still high after the last item.
    if (gap_before == 0) start <= 1'b0;
    while (chosen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && chosen_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
